// ----- rtl/utf8dec_pkg.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared types and constants for the UTF-8 to UCS-2 decoder unit.
// ----------------------------------------------------------------------------
package utf8dec_pkg;

  // Configuration port widths
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Result queue depth and pointer width
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;
  localparam int unsigned QueueCntW  = 3;

  // Register reset values
  localparam logic        StripBomRst = 1'b1;
  localparam logic [15:0] ReplCharRst = 16'd63;

  // Byte order mark code unit
  localparam logic [15:0] BomChar = 16'hFEFF;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_STRIP_BOM = 2'd0,
    CFG_REPL_CHAR = 2'd1
  } cfg_idx_e;

  // One result item
  typedef struct packed {
    logic [15:0] code_unit;
    logic        has_char;
    logic        out_last;
  } result_t;

endpackage : utf8dec_pkg

// ----- rtl/utf8dec_if.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder channel interfaces
// Byte input channel, code unit output channel and configuration write channel.
// ----------------------------------------------------------------------------

// Input byte channel
interface utf8dec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface : utf8dec_in_if

// Output code unit channel
interface utf8dec_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        has_char;
  logic        out_last;

  modport source (output valid, output code_unit, output has_char, output out_last,
                  input ready);
  modport sink   (input valid, input code_unit, input has_char, input out_last,
                  output ready);
endinterface : utf8dec_out_if

// Configuration write channel
interface utf8dec_cfg_if;
  import utf8dec_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : utf8dec_cfg_if

// ----- rtl/utf8_to_ucs2_decoder_unit.sv -----
// A byte taken is held in the input stage, then decoded into the result queue once it has room.
// Throughput: one byte per cycle while the single-read result queue of four entries has
// room for two results; a byte may yield two, so the drain rate of the queue sets the pace.
// Reset clears the queue, the input stage and the decode state; registers return to
// strip_bom = 1 and replacement_char = 63.
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder unit
// Decodes a UTF-8 byte stream into 16-bit code units, one byte per transfer.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_decoder_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  utf8dec_in_if.sink          in_i,
  utf8dec_out_if.source       out_o,
  utf8dec_cfg_if.sink         cfg_i
);
  import utf8dec_pkg::*;

  // Configuration registers
  logic        strip_bom_q;
  logic [15:0] repl_char_q;

  // Input stage
  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        last_q;

  // Decode state
  logic [1:0]  pend_q, pend_d;
  logic [15:0] acc_q, acc_d;
  logic        start_q, start_d;

  // Result queue
  result_t               queue_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0]  count_q;

  // Decode outputs
  logic        emit_a, emit_f, emit_z;
  logic [15:0] unit_f;
  result_t     slot0, slot1;
  logic [1:0]  n_res;

  logic        advance;
  logic        pop;
  logic [1:0]  push_n;

  // Configuration writes are always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_bom_q <= StripBomRst;
      repl_char_q <= ReplCharRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_STRIP_BOM: strip_bom_q <= cfg_i.data[0];
        CFG_REPL_CHAR: repl_char_q <= cfg_i.data[15:0];
        default:       ;
      endcase
    end
  end

  // The staged byte is decoded when the queue has room for two results.
  assign advance    = in_valid_q && (count_q <= QueueCntW'(QueueDepth - 2));
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.in_byte;
      last_q <= in_i.in_last;
    end
  end

  // Byte decode: interruption, fresh decode, then end-of-stream handling.
  always_comb begin
    pend_d  = pend_q;
    acc_d   = acc_q;
    start_d = start_q;
    emit_a  = 1'b0;
    emit_f  = 1'b0;
    emit_z  = 1'b0;
    unit_f  = '0;

    // A non-continuation byte breaks an open sequence
    if (pend_q != 2'd0 && byte_q[7:6] != 2'b10) begin
      emit_a  = 1'b1;
      start_d = 1'b0;
      pend_d  = 2'd0;
      acc_d   = '0;
    end

    if (!byte_q[7]) begin
      // Plain ASCII passes through
      unit_f  = {8'h00, byte_q};
      emit_f  = 1'b1;
      start_d = 1'b0;
    end else if (byte_q[7:6] == 2'b10) begin
      // Continuation byte; stray ones only end the stream start
      if (pend_d == 2'd0) begin
        start_d = 1'b0;
      end else begin
        acc_d  = {acc_d[9:0], byte_q[5:0]};
        pend_d = pend_d - 2'd1;
        if (pend_d == 2'd0) begin
          unit_f  = acc_d;
          emit_f  = !(start_d && strip_bom_q && acc_d == BomChar);
          start_d = 1'b0;
        end
      end
    end else if (byte_q[7:5] == 3'b110) begin
      acc_d  = {11'd0, byte_q[4:0]};
      pend_d = 2'd1;
    end else if (byte_q[7:4] == 4'b1110) begin
      acc_d  = {12'd0, byte_q[3:0]};
      pend_d = 2'd2;
    end else begin
      // Four-byte leads and invalid bytes
      unit_f  = repl_char_q;
      emit_f  = 1'b1;
      start_d = 1'b0;
    end

    // End of stream closes any open sequence and clears the state
    if (last_q) begin
      emit_z  = (pend_d != 2'd0);
      pend_d  = 2'd0;
      acc_d   = '0;
      start_d = 1'b1;
    end
  end

  // Pack the emissions into at most two result slots.
  always_comb begin
    n_res = 2'(emit_a) + 2'(emit_f) + 2'(emit_z);

    slot0.code_unit = emit_a ? repl_char_q : (emit_f ? unit_f : repl_char_q);
    slot0.has_char  = 1'b1;
    slot1.code_unit = (emit_a && emit_f) ? unit_f : repl_char_q;
    slot1.has_char  = 1'b1;
    slot1.out_last  = last_q;

    if (n_res == 2'd0 && last_q) begin
      // Bare end marker
      n_res           = 2'd1;
      slot0.code_unit = '0;
      slot0.has_char  = 1'b0;
    end
    slot0.out_last = last_q && (n_res == 2'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 2'd0;
      acc_q   <= '0;
      start_q <= 1'b1;
    end else if (advance) begin
      pend_q  <= pend_d;
      acc_q   <= acc_d;
      start_q <= start_d;
    end
  end

  // Result queue bookkeeping
  assign push_n = advance ? n_res : 2'd0;
  assign pop    = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QueuePtrW'(push_n);
      rd_ptr_q <= rd_ptr_q + QueuePtrW'(pop);
      count_q  <= count_q + QueueCntW'(push_n) - QueueCntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      queue_q[wr_ptr_q] <= slot0;
    end
    if (push_n == 2'd2) begin
      queue_q[wr_ptr_q + QueuePtrW'(1)] <= slot1;
    end
  end

  // Output channel shows the queue head
  assign out_o.valid     = (count_q != '0);
  assign out_o.code_unit = queue_q[rd_ptr_q].code_unit;
  assign out_o.has_char  = queue_q[rd_ptr_q].has_char;
  assign out_o.out_last  = queue_q[rd_ptr_q].out_last;

endmodule : utf8_to_ucs2_decoder_unit

// ----- rtl/utf8dec_checker.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder port checker
// Watches the decoder's ports over time and reports rule breaks.
// ----------------------------------------------------------------------------
module utf8dec_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] code_unit_i,
  input logic        has_char_i,
  input logic        out_last_i
);

  // A stalled result keeps its payload on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(code_unit_i) && $stable(has_char_i) && $stable(out_last_i))
    else $error("Stalled result changed or was withdrawn");

  // A bare end marker carries no character and always closes the stream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !has_char_i |-> out_last_i && code_unit_i == 16'd0)
    else $error("Bare end marker malformed");

  // The input is held off only while results are waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("Input stalled with an empty result queue");

  // Leaving reset, no result is present.
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("Result present straight after reset");

endmodule : utf8dec_checker

bind utf8_to_ucs2_decoder_unit utf8dec_checker u_utf8dec_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .code_unit_i (out_o.code_unit),
  .has_char_i  (out_o.has_char),
  .out_last_i  (out_o.out_last)
);
